>>> rtl/cfrf_pkg.sv
// Shared constants, types and a pointer-wrap helper for the CAN receive filter and FIFO.
package cfrf_pkg;

   localparam int NUM_FILTERS = 28;
   localparam int FIFO_DEPTH  = 3;

   localparam int ID_W        = 11;
   localparam int LEN_W       = 4;
   localparam int DATA_W      = 64;
   localparam int KIND_W      = 2;
   localparam int FIDX_W      = 5;
   localparam int COUNT_W     = 2;

   localparam int FILT_SEL_W  = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
   localparam int PTR_W       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FILL_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);

   typedef enum logic [KIND_W-1:0] {
      KIND_FRAME   = 2'd0,
      KIND_WRITE   = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_STATUS  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_RESP = 2'd2
   } state_type;

   typedef struct packed {
      logic load;
      logic execute;
   } cmd_type;

   function automatic logic [PTR_W-1:0] ptr_wrap(input logic [PTR_W:0] sum);
      logic [PTR_W:0] depth_ext;
      logic [PTR_W:0] res;
      depth_ext = (PTR_W + 1)'(FIFO_DEPTH);
      res = (sum >= depth_ext) ? (sum - depth_ext) : sum;
      return res[PTR_W-1:0];
   endfunction

endpackage

>>> rtl/can_rx_filter_fifo_core.sv
// Top level of the CAN receive acceptance filter and three-deep frame FIFO.
// The result word strobes on rsp_valid in the respond state, after the execute state.
// Words are taken one at a time, through the idle, execute and respond steps
// of the sequencer; the filter compare and FIFO update take place in the execute step.
// The receiver cannot stall: each result is presented for exactly one cycle.
// Reset: all filters inactive, FIFO empty, overrun clear, lock mode off.
module can_rx_filter_fifo_core
   import cfrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [FIDX_W-1:0]   req_filter_index,
   input  logic [ID_W-1:0]     req_filter_id,
   input  logic [ID_W-1:0]     req_filter_mask,
   input  logic                req_filter_enable,
   input  logic [ID_W-1:0]     req_frame_id,
   input  logic [LEN_W-1:0]    req_frame_len,
   input  logic [DATA_W-1:0]   req_frame_data,
   input  logic                req_clear_overrun,
   output logic                rsp_valid,
   output logic                rsp_accepted,
   output logic [COUNT_W-1:0]  rsp_fifo_count,
   output logic                rsp_overrun,
   output logic [ID_W-1:0]     rsp_head_id,
   output logic [LEN_W-1:0]    rsp_head_len,
   output logic [DATA_W-1:0]   rsp_head_data,
   input  logic                csr_write_enable,
   input  logic                csr_write_data
);

   cmd_type cmd;

   cfrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   cfrf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_kind          (req_kind),
      .req_filter_index  (req_filter_index),
      .req_filter_id     (req_filter_id),
      .req_filter_mask   (req_filter_mask),
      .req_filter_enable (req_filter_enable),
      .req_frame_id      (req_frame_id),
      .req_frame_len     (req_frame_len),
      .req_frame_data    (req_frame_data),
      .req_clear_overrun (req_clear_overrun),
      .rsp_accepted      (rsp_accepted),
      .rsp_fifo_count    (rsp_fifo_count),
      .rsp_overrun       (rsp_overrun),
      .rsp_head_id       (rsp_head_id),
      .rsp_head_len      (rsp_head_len),
      .rsp_head_data     (rsp_head_data)
   );

   a_strobe_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a busy window");

   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted word did not produce a result on time");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!busy && !cmd.execute))
      else $error("request latch loaded while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fifo_count <= COUNT_W'(FIFO_DEPTH)))
      else $error("fifo count above depth");

   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_fifo_count == '0)) |-> ((rsp_head_len == '0) && !rsp_accepted))
      else $error("empty fifo reported a head frame or acceptance");

endmodule

>>> rtl/cfrf_ctrl.sv
// Sequencer: accepts a word, runs it through the execute state and strobes the result.
module cfrf_ctrl
   import cfrf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_EXEC: cmd.execute = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: busy = 1'b1;
      endcase
   end

endmodule

>>> rtl/cfrf_datapath.sv
// Request latch, acceptance filter bank, frame FIFO and status outputs.
module cfrf_datapath
   import cfrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic                csr_write_enable,
   input  logic                csr_write_data,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [FIDX_W-1:0]   req_filter_index,
   input  logic [ID_W-1:0]     req_filter_id,
   input  logic [ID_W-1:0]     req_filter_mask,
   input  logic                req_filter_enable,
   input  logic [ID_W-1:0]     req_frame_id,
   input  logic [LEN_W-1:0]    req_frame_len,
   input  logic [DATA_W-1:0]   req_frame_data,
   input  logic                req_clear_overrun,
   output logic                rsp_accepted,
   output logic [COUNT_W-1:0]  rsp_fifo_count,
   output logic                rsp_overrun,
   output logic [ID_W-1:0]     rsp_head_id,
   output logic [LEN_W-1:0]    rsp_head_len,
   output logic [DATA_W-1:0]   rsp_head_data
);

   kind_type                kind_ff;
   logic [FIDX_W-1:0]       fidx_ff;
   logic [ID_W-1:0]         fid_ff;
   logic [ID_W-1:0]         fmask_ff;
   logic                    fen_ff;
   logic [ID_W-1:0]         id_ff;
   logic [LEN_W-1:0]        len_ff;
   logic [DATA_W-1:0]       data_ff;
   logic                    clr_ff;

   logic                    lock_ff;
   logic [NUM_FILTERS-1:0]  active_ff;
   logic [ID_W-1:0]         ident_ff [NUM_FILTERS];
   logic [ID_W-1:0]         mask_ff  [NUM_FILTERS];

   logic [ID_W-1:0]         fifo_id_ff   [FIFO_DEPTH];
   logic [LEN_W-1:0]        fifo_len_ff  [FIFO_DEPTH];
   logic [DATA_W-1:0]       fifo_data_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]        head_ff;
   logic [FILL_W-1:0]       fill_ff;
   logic                    overrun_ff;
   logic                    accepted_ff;

   logic                    hit;
   logic                    full;
   logic                    idx_ok;
   logic [FILT_SEL_W-1:0]   fsel;
   logic [PTR_W-1:0]        tail_slot;
   logic [PTR_W-1:0]        newest_slot;
   logic                    fifo_we;
   logic [PTR_W-1:0]        fifo_slot;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= kind_type'(req_kind);
         fidx_ff  <= req_filter_index;
         fid_ff   <= req_filter_id;
         fmask_ff <= req_filter_mask;
         fen_ff   <= req_filter_enable;
         id_ff    <= req_frame_id;
         len_ff   <= (req_frame_len > MAX_LEN) ? MAX_LEN : req_frame_len;
         data_ff  <= req_frame_data;
         clr_ff   <= req_clear_overrun;
      end
   end

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < NUM_FILTERS; i++) begin
         if (active_ff[i] && (((id_ff ^ ident_ff[i]) & mask_ff[i]) == '0)) hit = 1'b1;
      end
   end

   assign full        = (fill_ff == FILL_W'(FIFO_DEPTH));
   assign idx_ok      = ({1'b0, fidx_ff} < (FIDX_W + 1)'(NUM_FILTERS));
   assign fsel        = fidx_ff[FILT_SEL_W-1:0];
   assign tail_slot   = ptr_wrap((PTR_W + 1)'(head_ff) + (PTR_W + 1)'(fill_ff));
   assign newest_slot = ptr_wrap((PTR_W + 1)'(head_ff) + (PTR_W + 1)'(FIFO_DEPTH - 1));

   always_comb begin
      fifo_we   = 1'b0;
      fifo_slot = tail_slot;
      if (cmd.execute && (kind_ff == KIND_FRAME) && hit) begin
         if (!full) begin
            fifo_we = 1'b1;
         end else if (!lock_ff) begin
            fifo_we   = 1'b1;
            fifo_slot = newest_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_id_ff[fifo_slot]   <= id_ff;
         fifo_len_ff[fifo_slot]  <= len_ff;
         fifo_data_ff[fifo_slot] <= data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && (kind_ff == KIND_WRITE) && idx_ok) begin
         ident_ff[fsel] <= fid_ff;
         mask_ff[fsel]  <= fmask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff     <= 1'b0;
         active_ff   <= '0;
         head_ff     <= '0;
         fill_ff     <= '0;
         overrun_ff  <= 1'b0;
         accepted_ff <= 1'b0;
      end else begin
         if (csr_write_enable) lock_ff <= csr_write_data;
         if (cmd.execute) begin
            accepted_ff <= fifo_we;
            case (kind_ff)
               KIND_FRAME: begin
                  if (hit && full) overrun_ff <= 1'b1;
                  if (hit && !full) fill_ff <= fill_ff + FILL_W'(1);
               end
               KIND_WRITE: begin
                  if (idx_ok) active_ff[fsel] <= fen_ff;
               end
               KIND_RELEASE: begin
                  if (fill_ff != '0) begin
                     head_ff <= ptr_wrap((PTR_W + 1)'(head_ff) + (PTR_W + 1)'(1));
                     fill_ff <= fill_ff - FILL_W'(1);
                  end
                  if (clr_ff) overrun_ff <= 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_accepted   = accepted_ff;
   assign rsp_fifo_count = COUNT_W'(fill_ff);
   assign rsp_overrun    = overrun_ff;
   assign rsp_head_id    = (fill_ff != '0) ? fifo_id_ff[head_ff]   : '0;
   assign rsp_head_len   = (fill_ff != '0) ? fifo_len_ff[head_ff]  : '0;
   assign rsp_head_data  = (fill_ff != '0) ? fifo_data_ff[head_ff] : '0;

endmodule
